// ===== rtl/icd_pkg.sv =====
// Shared constants, codes, types and helpers of the inode cache directory.
package icd_pkg;

  localparam int CACHE_SLOTS     = 64;
  localparam int REFCOUNT_BITS   = 8;
  localparam int RESERVED_NUMBER = 1;
  localparam int MAX_OUT         = 64;

  localparam int SLOT_W   = $clog2(CACHE_SLOTS);
  localparam int CNT_W    = $clog2(CACHE_SLOTS + 1);
  localparam int FOUND_W  = $clog2(MAX_OUT + 1);

  localparam logic [31:0] RESERVED_TAG = 32'(RESERVED_NUMBER);

  localparam logic [1:0] OP_REQUEST    = 2'd0;
  localparam logic [1:0] OP_RELEASE    = 2'd1;
  localparam logic [1:0] OP_MARK_DIRTY = 2'd2;
  localparam logic [1:0] OP_FLUSH      = 2'd3;

  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_MISS      = 3'd1;
  localparam logic [2:0] ST_REJECT    = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_UNDERFLOW = 3'd4;

  typedef struct packed {
    logic                     dirty;
    logic [REFCOUNT_BITS-1:0] refcnt;
    logic [31:0]              tag;
  } entry_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot;
    logic        wb_valid;
    logic [31:0] wb_number;
    logic        fetch_valid;
    logic        last;
  } result_t;

  function automatic result_t make_result(logic [2:0] status, logic [5:0] slot,
                                          logic wb_valid, logic [31:0] wb_number,
                                          logic fetch_valid, logic last);
    result_t r;
    r.status      = status;
    r.slot        = slot;
    r.wb_valid    = wb_valid;
    r.wb_number   = wb_number;
    r.fetch_valid = fetch_valid;
    r.last        = last;
    return r;
  endfunction

endpackage

// ===== rtl/inode_cache_directory.sv =====
// Top level of the inode cache directory: sequencer, slot store and result register.
//
// Channel  Side    Signals                      Contents
// s_axis   slave   tvalid tready tdata tuser    one request: operation, number, slot
// m_axis   master  tvalid tready tdata tuser    one result; tlast marks the final one
//
// A request probes one slot a cycle through the slot RAM read port, at most CACHE_SLOTS
// slots, starting at the slot given by the low bits of the number.
// Release and mark dirty read their slot and then check it; flush reads and checks each slot in turn.
// Reset clears the per-slot valid bits at once, so no clearing pass runs.
// A result that is not taken stalls the sequencer; the slave side is ready only when idle.
module inode_cache_directory (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // object_number[31:0], slot_index[37:32], zero
  input  logic [1:0]  s_axis_tuser_i,   // operation[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // result_slot[5:0], writeback_valid[6],
                                        // writeback_number[38:7], fetch_valid[39]
  output logic [2:0]  m_axis_tuser_o,   // status[2:0]
  output logic        m_axis_tlast_o    // last_result
);
  import icd_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_PROBE   = 4'd2;
  localparam logic [3:0] S_RMW_RD  = 4'd3;
  localparam logic [3:0] S_RMW_CHK = 4'd4;
  localparam logic [3:0] S_FL_RD   = 4'd5;
  localparam logic [3:0] S_FL_CHK  = 4'd6;
  localparam logic [3:0] S_FL_END  = 4'd7;
  localparam logic [3:0] S_FIN     = 4'd8;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CACHE_SLOTS - 1);

  logic [3:0]             state_q, state_d;
  logic [1:0]             op_q, op_d;
  logic [31:0]            num_q, num_d;
  logic [SLOT_W-1:0]      slot_q, slot_d;
  logic [CNT_W-1:0]       iss_cnt_q, iss_cnt_d;
  logic                   chk_vld_q, chk_vld_d;
  logic [SLOT_W-1:0]      chk_slot_q, chk_slot_d;
  logic                   vic_found_q, vic_found_d;
  logic [SLOT_W-1:0]      vic_slot_q, vic_slot_d;
  logic                   vic_wb_q, vic_wb_d;
  logic [31:0]            vic_tag_q, vic_tag_d;
  result_t                res_q, res_d;
  logic                   wr_q, wr_d;
  logic [SLOT_W-1:0]      wr_addr_q, wr_addr_d;
  entry_t                 wr_data_q, wr_data_d;
  logic [FOUND_W-1:0]     found_q, found_d;
  logic                   out_vld_q, out_vld_d;
  result_t                out_q;
  logic [CACHE_SLOTS-1:0] valid_q, valid_d;

  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  entry_t            rd_data;
  entry_t            ent;
  logic              ram_we;
  logic              out_free;
  logic              out_load;
  logic              in_accept;
  logic [5:0]        in_idx;

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign in_idx    = s_axis_tdata_i[37:32];
  assign out_free  = !out_vld_q || m_axis_tready_i;
  assign ram_we    = (state_q == S_FIN) && out_free && wr_q;

  always_comb begin
    ent = rd_data;
    if (!valid_q[chk_slot_q]) begin
      ent.dirty  = 1'b0;
      ent.refcnt = '0;
      ent.tag    = RESERVED_TAG;
    end
  end

  always_comb begin
    logic [SLOT_W-1:0]        slot_next;
    logic [REFCOUNT_BITS-1:0] ref_inc;
    logic                     cand;
    logic [FOUND_W-1:0]       found_inc;
    state_d     = state_q;
    op_d        = op_q;
    num_d       = num_q;
    slot_d      = slot_q;
    iss_cnt_d   = iss_cnt_q;
    chk_vld_d   = chk_vld_q;
    chk_slot_d  = chk_slot_q;
    vic_found_d = vic_found_q;
    vic_slot_d  = vic_slot_q;
    vic_wb_d    = vic_wb_q;
    vic_tag_d   = vic_tag_q;
    res_d       = res_q;
    wr_d        = wr_q;
    wr_addr_d   = wr_addr_q;
    wr_data_d   = wr_data_q;
    found_d     = found_q;
    valid_d     = valid_q;
    rd_en       = 1'b0;
    rd_addr     = slot_q;
    out_load    = 1'b0;
    slot_next   = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
    ref_inc     = (ent.refcnt == '1) ? ent.refcnt : ent.refcnt + 1'b1;
    cand        = ent.dirty && (ent.tag != RESERVED_TAG);
    found_inc   = found_q + 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          op_d        = s_axis_tuser_i;
          num_d       = s_axis_tdata_i[31:0];
          wr_d        = 1'b0;
          iss_cnt_d   = '0;
          chk_vld_d   = 1'b0;
          vic_found_d = 1'b0;
          found_d     = '0;
          unique case (s_axis_tuser_i)
            OP_REQUEST: begin
              if (s_axis_tdata_i[31:0] <= RESERVED_TAG) begin
                res_d   = make_result(ST_REJECT, '0, 1'b0, '0, 1'b0, 1'b1);
                state_d = S_FIN;
              end else begin
                slot_d  = s_axis_tdata_i[SLOT_W-1:0];
                state_d = S_PROBE;
              end
            end
            OP_RELEASE, OP_MARK_DIRTY: begin
              if (32'(in_idx) < 32'(CACHE_SLOTS)) begin
                slot_d  = SLOT_W'(in_idx);
                state_d = S_RMW_RD;
              end else begin
                res_d   = make_result(ST_DONE, in_idx, 1'b0, '0, 1'b0, 1'b1);
                state_d = S_FIN;
              end
            end
            OP_FLUSH: begin
              slot_d  = '0;
              state_d = S_FL_RD;
            end
          endcase
        end
      end
      S_PROBE: begin
        rd_en     = iss_cnt_q != CNT_W'(CACHE_SLOTS);
        chk_vld_d = rd_en;
        if (rd_en) begin
          slot_d     = slot_next;
          iss_cnt_d  = iss_cnt_q + 1'b1;
          chk_slot_d = slot_q;
        end
        if (chk_vld_q) begin
          if (ent.tag == num_q) begin
            wr_d      = 1'b1;
            wr_addr_d = chk_slot_q;
            wr_data_d = {ent.dirty, ref_inc, ent.tag};
            res_d     = make_result(ST_DONE, 6'(chk_slot_q), 1'b0, '0, 1'b0, 1'b1);
            state_d   = S_FIN;
          end else if (!vic_found_q && (ent.tag == RESERVED_TAG || ent.refcnt == '0)) begin
            vic_found_d = 1'b1;
            vic_slot_d  = chk_slot_q;
            vic_wb_d    = cand;
            vic_tag_d   = ent.tag;
          end
        end else if (!rd_en) begin
          if (vic_found_q) begin
            wr_d      = 1'b1;
            wr_addr_d = vic_slot_q;
            wr_data_d = {1'b0, REFCOUNT_BITS'(1), num_q};
            res_d     = make_result(ST_MISS, 6'(vic_slot_q), vic_wb_q,
                                    vic_wb_q ? vic_tag_q : 32'd0, 1'b1, 1'b1);
          end else begin
            res_d = make_result(ST_FULL, '0, 1'b0, '0, 1'b0, 1'b1);
          end
          state_d = S_FIN;
        end
      end
      S_RMW_RD: begin
        rd_en      = 1'b1;
        chk_slot_d = slot_q;
        state_d    = S_RMW_CHK;
      end
      S_RMW_CHK: begin
        wr_addr_d = slot_q;
        res_d     = make_result(ST_DONE, 6'(slot_q), 1'b0, '0, 1'b0, 1'b1);
        if (op_q == OP_MARK_DIRTY) begin
          wr_d      = 1'b1;
          wr_data_d = {1'b1, ent.refcnt, ent.tag};
        end else if (ent.refcnt == '0) begin
          res_d.status = ST_UNDERFLOW;
        end else begin
          wr_d      = 1'b1;
          wr_data_d = {ent.dirty, ent.refcnt - 1'b1, ent.tag};
        end
        state_d = S_FIN;
      end
      S_FL_RD: begin
        rd_en      = 1'b1;
        chk_slot_d = slot_q;
        state_d    = S_FL_CHK;
      end
      S_FL_CHK: begin
        if (!(cand && found_q != '0 && !out_free)) begin
          if (cand) begin
            out_load = found_q != '0;
            res_d    = make_result(ST_DONE, 6'(chk_slot_q), 1'b1, ent.tag, 1'b0, 1'b0);
            found_d  = found_inc;
          end
          if ((cand && found_inc == FOUND_W'(MAX_OUT)) || slot_q == LAST_SLOT) begin
            state_d = S_FL_END;
          end else begin
            slot_d  = slot_next;
            state_d = S_FL_RD;
          end
        end
      end
      S_FL_END: begin
        if (found_q == '0) begin
          res_d = make_result(ST_DONE, '0, 1'b0, '0, 1'b0, 1'b1);
        end else begin
          res_d.last = 1'b1;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          if (wr_q) begin
            valid_d[wr_addr_q] = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      valid_q   <= '0;
      chk_vld_q <= 1'b0;
      wr_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      valid_q   <= valid_d;
      chk_vld_q <= chk_vld_d;
      wr_q      <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    num_q       <= num_d;
    slot_q      <= slot_d;
    iss_cnt_q   <= iss_cnt_d;
    chk_slot_q  <= chk_slot_d;
    vic_found_q <= vic_found_d;
    vic_slot_q  <= vic_slot_d;
    vic_wb_q    <= vic_wb_d;
    vic_tag_q   <= vic_tag_d;
    res_q       <= res_d;
    wr_addr_q   <= wr_addr_d;
    wr_data_q   <= wr_data_d;
    found_q     <= found_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  icd_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(CACHE_SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_addr_q),
    .wdata_i(wr_data_q),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  assign s_axis_tready_o = state_q == S_IDLE;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_q.fetch_valid, out_q.wb_number, out_q.wb_valid, out_q.slot};
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tlast_o  = out_q.last;

endmodule

// ===== rtl/icd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module icd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/icd_checker.sv =====
// Port-level checker of the inode cache directory and its bind to the top level.
module icd_assertions (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [39:0] s_axis_tdata_i,
  input logic [1:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);
  import icd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("Stalled result changed.");

  a_fetch_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[39] == (m_axis_tuser_o == ST_MISS))
    else $error("Fetch flag disagrees with miss status.");

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_REJECT || m_axis_tuser_o == ST_FULL
      || m_axis_tuser_o == ST_UNDERFLOW) |-> m_axis_tlast_o && m_axis_tdata_o[39:6] == '0)
    else $error("Error result carries data or is not final.");

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("Block ready right after taking a request.");

endmodule

bind inode_cache_directory icd_assertions u_icd_checker (.*);

// ===== test/icd_checker.sv =====
// Predicts the results of the inode cache directory and compares them with its result channel.
module icd_checker
  import icd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [39:0] s_axis_tdata_i,   // object_number[31:0], slot_index[37:32], zero
  input  logic [1:0]  s_axis_tuser_i,   // operation[1:0]
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [39:0] m_axis_tdata_i,   // result_slot[5:0], writeback_valid[6],
                                        // writeback_number[38:7], fetch_valid[39]
  input  logic [2:0]  m_axis_tuser_i,   // status[2:0]
  input  logic        m_axis_tlast_i,   // last_result
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0]              dir_tag   [CACHE_SLOTS];
  logic [REFCOUNT_BITS-1:0] dir_refs  [CACHE_SLOTS];
  logic                     dir_dirty [CACHE_SLOTS];
  result_t                  expected_q[$];
  int                       mismatches = 0;

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  function automatic result_t outcome(logic [2:0] status, logic [5:0] slot, logic wb_valid,
                                      logic [31:0] wb_number, logic fetch_valid, logic last);
    result_t r;
    r.status      = status;
    r.slot        = slot;
    r.wb_valid    = wb_valid;
    r.wb_number   = wb_number;
    r.fetch_valid = fetch_valid;
    r.last        = last;
    return r;
  endfunction

  task automatic predict_directory(input logic [1:0] op, input logic [31:0] num,
                                   input logic [5:0] idx);
    int      s;
    int      n;
    bit      done;
    bit      have;
    logic    wbv;
    result_t held;
    logic [2:0] st;
    done = 1'b0;
    have = 1'b0;
    n    = 0;
    case (op)
      OP_REQUEST: begin
        if (num <= RESERVED_TAG) begin
          expected_q.push_back(outcome(ST_REJECT, 6'd0, 1'b0, 32'd0, 1'b0, 1'b1));
        end else begin
          for (int k = 0; k < CACHE_SLOTS; k++) begin
            s = (int'(num[5:0]) + k) % CACHE_SLOTS;
            if (!done && dir_tag[s] == num) begin
              if (dir_refs[s] != '1) dir_refs[s] = dir_refs[s] + 1'b1;
              expected_q.push_back(outcome(ST_DONE, 6'(s), 1'b0, 32'd0, 1'b0, 1'b1));
              done = 1'b1;
            end
          end
          for (int k = 0; k < CACHE_SLOTS; k++) begin
            s = (int'(num[5:0]) + k) % CACHE_SLOTS;
            if (!done && (dir_tag[s] == RESERVED_TAG || dir_refs[s] == '0)) begin
              wbv = dir_dirty[s] && dir_tag[s] != RESERVED_TAG;
              expected_q.push_back(outcome(ST_MISS, 6'(s), wbv, wbv ? dir_tag[s] : 32'd0,
                                           1'b1, 1'b1));
              dir_tag[s]   = num;
              dir_dirty[s] = 1'b0;
              dir_refs[s]  = REFCOUNT_BITS'(1);
              done = 1'b1;
            end
          end
          if (!done) begin
            expected_q.push_back(outcome(ST_FULL, 6'd0, 1'b0, 32'd0, 1'b0, 1'b1));
          end
        end
      end
      OP_RELEASE: begin
        st = ST_DONE;
        if (dir_refs[idx] == '0) st = ST_UNDERFLOW;
        else dir_refs[idx] = dir_refs[idx] - 1'b1;
        expected_q.push_back(outcome(st, idx, 1'b0, 32'd0, 1'b0, 1'b1));
      end
      OP_MARK_DIRTY: begin
        dir_dirty[idx] = 1'b1;
        expected_q.push_back(outcome(ST_DONE, idx, 1'b0, 32'd0, 1'b0, 1'b1));
      end
      default: begin
        for (int k = 0; k < CACHE_SLOTS && n < MAX_OUT; k++) begin
          if (dir_dirty[k] && dir_tag[k] != RESERVED_TAG) begin
            if (have) expected_q.push_back(held);
            held = outcome(ST_DONE, 6'(k), 1'b1, dir_tag[k], 1'b0, 1'b0);
            have = 1'b1;
            n++;
          end
        end
        if (have) begin
          held.last = 1'b1;
          expected_q.push_back(held);
        end else begin
          expected_q.push_back(outcome(ST_DONE, 6'd0, 1'b0, 32'd0, 1'b0, 1'b1));
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      for (int k = 0; k < CACHE_SLOTS; k++) begin
        dir_tag[k]   = RESERVED_TAG;
        dir_refs[k]  = '0;
        dir_dirty[k] = 1'b0;
      end
      expected_q.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = outcome(m_axis_tuser_i, m_axis_tdata_i[5:0], m_axis_tdata_i[6],
                      m_axis_tdata_i[38:7], m_axis_tdata_i[39], m_axis_tlast_i);
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected result status=%0d slot=%0d wb=%0d/%h fetch=%0d last=%0d",
                     $realtime, got.status, got.slot, got.wb_valid, got.wb_number,
                     got.fetch_valid, got.last);
          end
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status || got.slot !== want.slot ||
              got.wb_valid !== want.wb_valid || got.wb_number !== want.wb_number ||
              got.fetch_valid !== want.fetch_valid || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected status=%0d slot=%0d wb=%0d/%h fetch=%0d last=%0d",
                       want.status, want.slot, want.wb_valid, want.wb_number,
                       want.fetch_valid, want.last);
              $display("  actual   status=%0d slot=%0d wb=%0d/%h fetch=%0d last=%0d",
                       got.status, got.slot, got.wb_valid, got.wb_number,
                       got.fetch_valid, got.last);
            end
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_directory(s_axis_tuser_i, s_axis_tdata_i[31:0], s_axis_tdata_i[37:32]);
      end
    end
    errors_o  = mismatches;
    pending_o = expected_q.size();
  end

endmodule

// ===== test/testbench.sv =====
// Stimulus, clock, reset and verdict for the inode cache directory regression.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import icd_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i  = '0;
  logic [1:0]  s_axis_tuser_i  = OP_REQUEST;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  int errors;
  int pending;
  int cycle_count = 0;
  int hold_cnt    = 0;
  bit calm        = 1'b0;

  always #5ns clk_i = ~clk_i;

  inode_cache_directory u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  icd_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .m_axis_tlast_i  (m_axis_tlast_o),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt        <= hold_cnt - 1;
      m_axis_tready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      hold_cnt        <= $urandom_range(1, 13) - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  task automatic issue(input logic [1:0] op, input logic [31:0] num, input logic [5:0] idx);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, idx, num};
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  function automatic logic [31:0] pick_number();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 32'($urandom_range(0, 1));
    if (r < 65) return {26'($urandom_range(1, 10)), 6'($urandom_range(0, 15))};
    return $urandom;
  endfunction

  initial begin
    int          r;
    logic [31:0] num;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    issue(OP_FLUSH, 32'd0, 6'd0);
    issue(OP_REQUEST, 32'd0, 6'd0);
    issue(OP_REQUEST, RESERVED_TAG, 6'd0);
    issue(OP_REQUEST, 32'd2, 6'd0);
    issue(OP_REQUEST, 32'd2, 6'd0);
    issue(OP_REQUEST, 32'hFFFF_FFFF, 6'd0);
    issue(OP_REQUEST, 32'h8000_0002, 6'd0);
    issue(OP_REQUEST, 32'h0000_0042, 6'd0);
    issue(OP_MARK_DIRTY, 32'd0, 6'd3);
    issue(OP_MARK_DIRTY, 32'd0, 6'd10);
    issue(OP_FLUSH, 32'd0, 6'd0);
    issue(OP_RELEASE, 32'd0, 6'd3);
    issue(OP_REQUEST, 32'h0000_0083, 6'd0);
    issue(OP_RELEASE, 32'd0, 6'd2);
    issue(OP_RELEASE, 32'd0, 6'd2);
    issue(OP_RELEASE, 32'd0, 6'd2);
    issue(OP_RELEASE, 32'd0, 6'd0);
    issue(OP_MARK_DIRTY, 32'd0, 6'd63);
    issue(OP_MARK_DIRTY, 32'd0, 6'd0);
    issue(OP_FLUSH, 32'hFFFF_FFFF, 6'd63);
    issue(OP_REQUEST, 32'hFFFF_FFC0, 6'd0);
    issue(OP_RELEASE, 32'd0, 6'd63);
    issue(OP_REQUEST, 32'h7FFF_FFFF, 6'd63);
    drain();

    for (int i = 0; i < 200; i++) begin
      if (i == 70 || i == 140) drain();
      if (i == 100) begin
        repeat (70) begin
          num = $urandom;
          if (num <= RESERVED_TAG) num = 32'd2;
          issue(OP_REQUEST, num, 6'($urandom_range(0, 63)));
        end
      end
      if (i == 170) calm = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 50) issue(OP_REQUEST, pick_number(), 6'($urandom_range(0, 63)));
      else if (r < 70) issue(OP_RELEASE, $urandom, 6'($urandom_range(0, 63)));
      else if (r < 88) issue(OP_MARK_DIRTY, $urandom, 6'($urandom_range(0, 63)));
      else issue(OP_FLUSH, $urandom, 6'($urandom_range(0, 63)));
    end

    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== inode_cache_directory.f =====
rtl/icd_pkg.sv
rtl/icd_ram.sv
rtl/inode_cache_directory.sv
rtl/icd_checker.sv
test/icd_checker.sv
test/testbench.sv
